// ===== rtl/core/fcp_pkg.sv =====
package fcp_pkg;

    // parse phase of the front end
    typedef enum logic [1:0] {
        PH_CMD,
        PH_SKIP,
        PH_PARAM,
        PH_DONE
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_LETTER = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int          COUNT_W      = 11;
    localparam logic [10:0] COUNT_MAX    = 11'd2047;
    localparam int          NUM_CMDS     = 27;
    localparam logic [4:0]  CODE_UNKNOWN = 5'd27;
    localparam int          QUEUE_DEPTH  = 2;

    // first letter in the top byte, short names padded with zero bytes
    localparam logic [31:0] CMD_NAMES [NUM_CMDS] = '{
        "NOOP", "QUIT", {"PWD", 8'h00}, {"CWD", 8'h00}, "CDUP", "MODE",
        "STRU", "TYPE", "PASV", "PORT", "NLST", "LIST", "DELE", "RETR",
        {"MKD", 8'h00}, {"RMD", 8'h00}, "RNFR", "RNTO", "FEAT", "MDTM",
        "SIZE", "SITE", "STAT", "SYST", "AUTH", "USER", "PASS"
    };

    localparam logic [3:0] CMD_LENS [NUM_CMDS] = '{
        4'd4, 4'd4, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
    };

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    // unused letter bytes are zero, so name and length compare exactly
    function automatic logic [4:0] cmd_lookup(input logic [31:0] name,
                                              input logic [3:0]  cnt);
        logic [4:0] code;
        code = CODE_UNKNOWN;
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (name == CMD_NAMES[k] && cnt == CMD_LENS[k]) begin
                code = 5'(k);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/ftp_command_line_parser_unit.sv =====
// FTP control-line parser.
// Input channel (s_*): one byte of a control message per item, s_last on the
// final byte, s_connection names the client slot. Output channel (m_*): one
// item per message, produced from the last byte: status, command code, and
// parameter offset and length, with the slot echoed.
// cfg_wr_en / cfg_wr_data write the parameter size limit (reset 263); write
// it only while no message is in flight.
// Throughput: one byte per cycle while s_ready is high; the front-end parse
// FSM updates its phase and counters once for each byte taken.
// After the last byte is taken, its record is written into the record
// queue and from there taken into the output register.
// A two-entry record queue sits between the parser and the result stage; if
// the receiver stalls, bytes keep flowing until both entries and the output
// register hold results, then s_ready drops.
// Reset: parse state back to the start of a message, queue and output empty,
// limit back to 263.
module ftp_command_line_parser_unit
    import fcp_pkg::*;
#(
    parameter int CMD_LETTERS = 4,
    parameter int LINE_MAX    = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    input  logic [3:0] s_connection,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [4:0] m_command_code,
    output logic [9:0] m_param_start,
    output logic [9:0] m_param_len,
    output logic [3:0] m_connection_out,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data
);

    localparam int LCW = $clog2(CMD_LETTERS + 1);
    localparam int PW  = $clog2(LINE_MAX + 1);
    // record: fault, letters, letter count, param start, param count, slot
    localparam int RW  = 2 + 8 * CMD_LETTERS + LCW + PW + COUNT_W + 4;

    logic          push, push_ready, pop_valid, pop;
    logic [RW-1:0] push_data, pop_data;

    // parser: per-byte phase tracking, emits one record per message
    fcp_front #(
        .CMD_LETTERS (CMD_LETTERS),
        .LINE_MAX    (LINE_MAX),
        .LCW         (LCW),
        .PW          (PW),
        .RW          (RW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (s_data_byte),
        .in_last   (s_last),
        .in_conn   (s_connection),
        .rec_push  (push),
        .rec_ready (push_ready),
        .rec_data  (push_data)
    );

    fcp_queue #(
        .WIDTH (RW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // result stage: limit check, command lookup, output register
    fcp_back #(
        .CMD_LETTERS (CMD_LETTERS),
        .LINE_MAX    (LINE_MAX),
        .LCW         (LCW),
        .PW          (PW),
        .RW          (RW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rec_valid   (pop_valid),
        .rec_pop     (pop),
        .rec_data    (pop_data),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_status  (m_status),
        .out_code    (m_command_code),
        .out_start   (m_param_start),
        .out_len     (m_param_len),
        .out_conn    (m_connection_out)
    );

endmodule

// ===== rtl/core/fcp_front.sv =====
module fcp_front
    import fcp_pkg::*;
#(
    parameter int CMD_LETTERS = 4,
    parameter int LINE_MAX    = 1024,
    parameter int LCW         = $clog2(CMD_LETTERS + 1),
    parameter int PW          = $clog2(LINE_MAX + 1),
    parameter int RW          = 2 + 8 * CMD_LETTERS + LCW + PW + COUNT_W + 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic [3:0]    in_conn,
    output logic          rec_push,
    input  logic          rec_ready,
    output logic [RW-1:0] rec_data
);

    localparam int IW = (CMD_LETTERS > 1) ? $clog2(CMD_LETTERS) : 1;

    phase_t             phase_reg, phase_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [7:0]         letters_reg [CMD_LETTERS];
    logic [7:0]         letters_next [CMD_LETTERS];
    logic [LCW-1:0]     lc_reg, lc_next;
    logic [PW-1:0]      pb_reg, pb_next;
    logic [COUNT_W-1:0] pc_reg, pc_next;
    logic [1:0]         fault_reg, fault_next;

    logic [PW-1:0]         rec_pb;
    logic [COUNT_W-1:0]    rec_pc;
    logic [8*CMD_LETTERS-1:0] letters_flat;
    logic                  accept;

    assign in_ready = rec_ready;
    assign accept   = in_valid && rec_ready;
    assign rec_push = accept && in_last;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        lc_next    = lc_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        fault_next = fault_reg;
        for (int j = 0; j < CMD_LETTERS; j++) begin
            letters_next[j] = letters_reg[j];
        end

        case (phase_reg)
            PH_CMD: begin
                if (lc_reg < LCW'(CMD_LETTERS) && is_letter(in_byte)) begin
                    letters_next[lc_reg[IW-1:0]] = in_byte;
                    lc_next = lc_reg + LCW'(1);
                end else if (lc_reg == '0) begin
                    fault_next = ST_NO_LETTER;
                    phase_next = PH_DONE;
                end else if (in_byte == CH_SPACE) begin
                    phase_next = PH_SKIP;
                end else if (is_eol(in_byte)) begin
                    pb_next    = pos_reg;
                    pc_next    = '0;
                    phase_next = PH_DONE;
                end else begin
                    fault_next = ST_NO_SPACE;
                    phase_next = PH_DONE;
                end
            end
            PH_SKIP: begin
                if (in_byte != CH_SPACE) begin
                    pb_next = pos_reg;
                    if (is_eol(in_byte)) begin
                        pc_next    = '0;
                        phase_next = PH_DONE;
                    end else begin
                        pc_next    = COUNT_W'(1);
                        phase_next = PH_PARAM;
                    end
                end
            end
            PH_PARAM: begin
                if (is_eol(in_byte)) begin
                    phase_next = PH_DONE;
                end else if (pc_reg < COUNT_MAX) begin
                    pc_next = pc_reg + COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (pos_reg < PW'(LINE_MAX)) begin
            pos_next = pos_reg + PW'(1);
        end

        // message ended inside the command or the spaces: empty parameter
        if (fault_next == ST_OK && (phase_next == PH_CMD || phase_next == PH_SKIP)) begin
            rec_pb = pos_next;
            rec_pc = '0;
        end else begin
            rec_pb = pb_next;
            rec_pc = pc_next;
        end

        for (int j = 0; j < CMD_LETTERS; j++) begin
            letters_flat[8*j +: 8] = letters_next[j];
        end
        rec_data = {fault_next, letters_flat, lc_next, rec_pb, rec_pc, in_conn};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            phase_reg <= PH_CMD;
            pos_reg   <= '0;
            lc_reg    <= '0;
            pb_reg    <= '0;
            pc_reg    <= '0;
            fault_reg <= ST_OK;
            for (int j = 0; j < CMD_LETTERS; j++) begin
                letters_reg[j] <= '0;
            end
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            lc_reg    <= lc_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            fault_reg <= fault_next;
            for (int j = 0; j < CMD_LETTERS; j++) begin
                letters_reg[j] <= letters_next[j];
            end
        end
    end

endmodule

// ===== rtl/core/fcp_queue.sv =====
module fcp_queue
    import fcp_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != NW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/fcp_back.sv =====
module fcp_back
    import fcp_pkg::*;
#(
    parameter int CMD_LETTERS = 4,
    parameter int LINE_MAX    = 1024,
    parameter int LCW         = $clog2(CMD_LETTERS + 1),
    parameter int PW          = $clog2(LINE_MAX + 1),
    parameter int RW          = 2 + 8 * CMD_LETTERS + LCW + PW + COUNT_W + 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [9:0]    cfg_wr_data,
    input  logic          rec_valid,
    output logic          rec_pop,
    input  logic [RW-1:0] rec_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_status,
    output logic [4:0]    out_code,
    output logic [9:0]    out_start,
    output logic [9:0]    out_len,
    output logic [3:0]    out_conn
);

    localparam int EW = (PW > 10) ? PW : 10;

    logic [9:0] limit_reg;
    logic       valid_reg;
    logic [1:0] status_reg;
    logic [4:0] code_reg;
    logic [9:0] start_reg, len_reg;
    logic [3:0] conn_reg;

    logic [1:0]               r_fault;
    logic [8*CMD_LETTERS-1:0] r_letters;
    logic [LCW-1:0]           r_lc;
    logic [PW-1:0]            r_pb;
    logic [COUNT_W-1:0]       r_pc;
    logic [3:0]               r_conn;
    logic [31:0]              name4;
    logic [EW-1:0]            pb_ext;
    logic [1:0]               st;
    logic [4:0]               code;
    logic [9:0]               start, len;

    assign {r_fault, r_letters, r_lc, r_pb, r_pc, r_conn} = rec_data;
    assign rec_pop = rec_valid && (!valid_reg || out_ready);

    always_comb begin
        name4 = '0;
        for (int j = 0; j < 4; j++) begin
            if (j < CMD_LETTERS) begin
                name4[31 - 8*j -: 8] = r_letters[8*j +: 8];
            end
        end
        pb_ext = EW'(r_pb);

        st = r_fault;
        if (st == ST_OK && ({1'b0, r_pc} + 12'd1) >= {2'b00, limit_reg}) begin
            st = ST_TOO_LONG;
        end

        if (st == ST_OK) begin
            code  = cmd_lookup(name4, 4'(r_lc));
            start = (pb_ext > EW'(1023)) ? 10'd1023 : pb_ext[9:0];
            len   = r_pc[9:0];
        end else begin
            code  = CODE_UNKNOWN;
            start = '0;
            len   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 10'd263;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (rec_pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            status_reg <= st;
            code_reg   <= code;
            start_reg  <= start;
            len_reg    <= len;
            conn_reg   <= r_conn;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_code   = code_reg;
    assign out_start  = start_reg;
    assign out_len    = len_reg;
    assign out_conn   = conn_reg;

endmodule
